// ----- hdl/mma_pkg.sv -----
package mma_pkg;

    localparam int SAMPLE_W = 16;
    localparam int CHAN_W   = 4;
    localparam int USED_W   = 5;
    localparam int MASK_W   = 10;
    localparam logic [MASK_W-1:0] MASK_RESET = 10'd1;

    localparam int STEP_W = 3;
    typedef logic [STEP_W-1:0] step_t;

    localparam step_t STEP_WAIT     = 3'd0;
    localparam step_t STEP_UPDATE   = 3'd1;
    localparam step_t STEP_READ     = 3'd2;
    localparam step_t STEP_ACC      = 3'd3;
    localparam step_t STEP_DIV_INIT = 3'd4;
    localparam step_t STEP_DIV      = 3'd5;
    localparam step_t STEP_FIX      = 3'd6;
    localparam step_t STEP_EMIT     = 3'd7;

    typedef enum logic [2:0] {
        OP_ACCEPT,
        OP_UPDATE,
        OP_READ,
        OP_ACC,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_FIX,
        OP_EMIT
    } op_t;

    typedef enum logic [2:0] {
        COND_NONE,
        COND_NO_ITEM,
        COND_MORE,
        COND_DIV_MORE,
        COND_OUT_BUSY
    } cond_t;

    typedef struct packed {
        logic  in_ready;
        op_t   op;
        cond_t cond;
        step_t target;
    } ctrl_t;

    typedef struct packed {
        logic item_ok;
        logic more;
        logic div_more;
        logic out_busy;
    } status_t;

endpackage

// ----- hdl/mma_if.sv -----
interface mma_in_if;
    import mma_pkg::*;

    logic                valid;
    logic                ready;
    logic [CHAN_W-1:0]   channel;
    logic [SAMPLE_W-1:0] sample;

    modport source (output valid, output channel, output sample, input ready);
    modport sink (input valid, input channel, input sample, output ready);
endinterface

interface mma_out_if;
    import mma_pkg::*;

    logic                valid;
    logic                ready;
    logic [CHAN_W-1:0]   result_channel;
    logic [SAMPLE_W-1:0] mean_value;
    logic [USED_W-1:0]   samples_used;

    modport source (
        output valid, output result_channel, output mean_value, output samples_used,
        input ready
    );
    modport sink (
        input valid, input result_channel, input mean_value, input samples_used,
        output ready
    );
endinterface

// ----- hdl/multichannel_moving_average.sv -----
// The block handles one item at a time: once an item is accepted, the input stays closed
// while its sum is walked over the sample memory read port and divided by the bit-serial
// divider, and the next item is taken in the cycle after the result is registered.
// Reset clears the sequencer, ring pointers, fill counts and the output valid, and sets
// the signed mask to one; the sample memory is not cleared.
module multichannel_moving_average #(
    parameter int WINDOW   = 16,
    parameter int CHANNELS = 10
) (
    input  logic                         clk,
    input  logic                         rst_n,
    mma_in_if.sink                       din,
    mma_out_if.source                    dout,
    input  logic                         cfg_we,
    input  logic [mma_pkg::MASK_W-1:0]   cfg_wdata
);
    import mma_pkg::*;

    localparam int IDXW = $clog2(WINDOW);
    localparam int UW   = $clog2(WINDOW + 1);
    localparam int CHW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int MAGW = SAMPLE_W + IDXW;
    localparam int SUMW = MAGW + 1;
    localparam int CNTW = $clog2(MAGW + 1);
    localparam int AW   = CHW + IDXW;
    localparam int MEMD = CHANNELS << IDXW;

    ctrl_t   ctrl;
    status_t status;

    logic [MASK_W-1:0]   mask_reg;
    logic [IDXW-1:0]     wp_reg [CHANNELS];
    logic [IDXW-1:0]     wp_next [CHANNELS];
    logic [UW-1:0]       fill_reg [CHANNELS];
    logic [UW-1:0]       fill_next [CHANNELS];
    logic                out_valid_reg;
    logic                out_valid_next;

    logic [CHAN_W-1:0]   ch_reg, ch_next;
    logic [SAMPLE_W-1:0] smp_reg, smp_next;
    logic                sgn_reg, sgn_next;
    logic [UW-1:0]       used_reg, used_next;
    logic [UW-1:0]       idx_reg, idx_next;
    logic [SUMW-1:0]     sum_reg, sum_next;
    logic [UW-1:0]       rem_reg, rem_next;
    logic [MAGW-1:0]     q_reg, q_next;
    logic                neg_reg, neg_next;
    logic [CNTW-1:0]     cnt_reg, cnt_next;
    logic [SAMPLE_W-1:0] mean_reg, mean_next;
    logic [CHAN_W-1:0]   res_ch_reg;
    logic [SAMPLE_W-1:0] res_mean_reg;
    logic [USED_W-1:0]   res_used_reg;

    logic [SAMPLE_W-1:0] mem [MEMD];
    logic [SAMPLE_W-1:0] rd_data_reg;
    logic                mem_we;
    logic [AW-1:0]       wr_addr;
    logic [AW-1:0]       rd_addr;

    logic [CHW-1:0]      ch_idx;
    logic [15:0]         mask_ext;
    logic                in_range;
    logic                accept;
    logic                load_out;
    logic [SUMW-1:0]     rd_ext;
    logic [SUMW-1:0]     sum_abs;
    logic [UW:0]         trial;
    logic                trial_ge;

    mma_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    assign din.ready = ctrl.in_ready;
    assign in_range  = ({1'b0, din.channel} < (CHAN_W + 1)'(CHANNELS));
    assign accept    = din.valid && ctrl.in_ready;
    assign mask_ext  = 16'(mask_reg);
    assign ch_idx    = ch_reg[CHW-1:0];

    assign status.item_ok  = din.valid && in_range;
    assign status.more     = (idx_reg != used_reg);
    assign status.div_more = (cnt_reg != CNTW'(1));
    assign status.out_busy = out_valid_reg && !dout.ready;

    assign load_out = (ctrl.op == OP_EMIT) && !status.out_busy;

    assign mem_we  = (ctrl.op == OP_UPDATE);
    assign wr_addr = {ch_idx, wp_reg[ch_idx]};
    assign rd_addr = {ch_idx, idx_reg[IDXW-1:0]};

    assign rd_ext  = sgn_reg ? {{(SUMW - SAMPLE_W){rd_data_reg[SAMPLE_W-1]}}, rd_data_reg}
                             : {{(SUMW - SAMPLE_W){1'b0}}, rd_data_reg};
    assign sum_abs = sum_reg[SUMW-1] ? (~sum_reg + 1'b1) : sum_reg;
    assign trial    = {rem_reg, q_reg[MAGW-1]};
    assign trial_ge = (trial >= {1'b0, used_reg});

    always_comb
    begin
        wp_next   = wp_reg;
        fill_next = fill_reg;
        ch_next   = ch_reg;
        smp_next  = smp_reg;
        sgn_next  = sgn_reg;
        used_next = used_reg;
        idx_next  = idx_reg;
        sum_next  = sum_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        mean_next = mean_reg;
        case (ctrl.op)
            OP_ACCEPT:
            begin
                if (accept)
                begin
                    ch_next  = din.channel;
                    smp_next = din.sample;
                    sgn_next = mask_ext[din.channel];
                end
            end
            OP_UPDATE:
            begin
                idx_next = '0;
                wp_next[ch_idx] = (wp_reg[ch_idx] == IDXW'(WINDOW - 1))
                                  ? '0 : wp_reg[ch_idx] + 1'b1;
                if (fill_reg[ch_idx] != UW'(WINDOW))
                begin
                    fill_next[ch_idx] = fill_reg[ch_idx] + 1'b1;
                    used_next         = fill_reg[ch_idx] + 1'b1;
                end
                else
                begin
                    used_next = fill_reg[ch_idx];
                end
            end
            OP_READ:
            begin
                idx_next = UW'(1);
                sum_next = '0;
            end
            OP_ACC:
            begin
                sum_next = sum_reg + rd_ext;
                idx_next = idx_reg + 1'b1;
            end
            OP_DIV_INIT:
            begin
                neg_next = sum_reg[SUMW-1];
                q_next   = sum_abs[MAGW-1:0];
                rem_next = '0;
                cnt_next = CNTW'(MAGW);
            end
            OP_DIV_STEP:
            begin
                if (trial_ge)
                begin
                    rem_next = UW'(trial - {1'b0, used_reg});
                end
                else
                begin
                    rem_next = trial[UW-1:0];
                end
                q_next   = {q_reg[MAGW-2:0], trial_ge};
                cnt_next = cnt_reg - 1'b1;
            end
            OP_FIX:
            begin
                mean_next = neg_reg ? (~q_reg[SAMPLE_W-1:0] + 1'b1) : q_reg[SAMPLE_W-1:0];
            end
            OP_EMIT:
            begin
                mean_next = mean_reg;
            end
            default:
            begin
                mean_next = mean_reg;
            end
        endcase

        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (dout.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= MASK_RESET;
            out_valid_reg <= 1'b0;
            for (int c = 0; c < CHANNELS; c++)
            begin
                wp_reg[c]   <= '0;
                fill_reg[c] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                mask_reg <= cfg_wdata;
            end
            out_valid_reg <= out_valid_next;
            wp_reg        <= wp_next;
            fill_reg      <= fill_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg   <= ch_next;
        smp_reg  <= smp_next;
        sgn_reg  <= sgn_next;
        used_reg <= used_next;
        sum_reg  <= sum_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        neg_reg  <= neg_next;
        mean_reg <= mean_next;
        if (load_out)
        begin
            res_ch_reg   <= ch_reg;
            res_mean_reg <= mean_reg;
            res_used_reg <= USED_W'(used_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= smp_reg;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign dout.valid          = out_valid_reg;
    assign dout.result_channel = res_ch_reg;
    assign dout.mean_value     = res_mean_reg;
    assign dout.samples_used   = res_used_reg;

endmodule

// ----- hdl/mma_seq.sv -----
module mma_seq (
    input  logic             clk,
    input  logic             rst_n,
    input  mma_pkg::status_t status,
    output mma_pkg::ctrl_t   ctrl
);
    import mma_pkg::*;

    step_t step_reg;
    step_t step_next;
    logic  jump;

    function automatic ctrl_t ucode(input step_t s);
        ctrl_t w;
        begin
            w = '{in_ready: 1'b0, op: OP_ACCEPT, cond: COND_NONE, target: STEP_WAIT};
            case (s)
                STEP_WAIT:
                begin
                    w = '{in_ready: 1'b1, op: OP_ACCEPT, cond: COND_NO_ITEM,
                          target: STEP_WAIT};
                end
                STEP_UPDATE:   w.op = OP_UPDATE;
                STEP_READ:     w.op = OP_READ;
                STEP_ACC:
                begin
                    w.op = OP_ACC;
                    w.cond = COND_MORE;
                    w.target = STEP_ACC;
                end
                STEP_DIV_INIT: w.op = OP_DIV_INIT;
                STEP_DIV:
                begin
                    w.op = OP_DIV_STEP;
                    w.cond = COND_DIV_MORE;
                    w.target = STEP_DIV;
                end
                STEP_FIX:      w.op = OP_FIX;
                STEP_EMIT:
                begin
                    w.op = OP_EMIT;
                    w.cond = COND_OUT_BUSY;
                    w.target = STEP_EMIT;
                end
                default:       w.op = OP_ACCEPT;
            endcase
            return w;
        end
    endfunction

    assign ctrl = ucode(step_reg);

    always_comb
    begin
        case (ctrl.cond)
            COND_NONE:     jump = 1'b0;
            COND_NO_ITEM:  jump = !status.item_ok;
            COND_MORE:     jump = status.more;
            COND_DIV_MORE: jump = status.div_more;
            COND_OUT_BUSY: jump = status.out_busy;
            default:       jump = 1'b0;
        endcase
        // The last step falls through to the first one by wrapping the counter.
        step_next = jump ? ctrl.target : step_t'(step_reg + 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_WAIT;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

// ----- hdl/mma_checker.sv -----
module mma_checker #(
    parameter int WINDOW   = 16,
    parameter int CHANNELS = 10
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          din_valid,
    input logic                          din_ready,
    input logic [mma_pkg::CHAN_W-1:0]    din_channel,
    input logic                          dout_valid,
    input logic                          dout_ready,
    input logic [mma_pkg::CHAN_W-1:0]    dout_result_channel,
    input logic [mma_pkg::SAMPLE_W-1:0]  dout_mean_value,
    input logic [mma_pkg::USED_W-1:0]    dout_samples_used
);
    import mma_pkg::*;

    // An accepted item for a real channel keeps the input closed until its result is ready.
    a_busy_after_item: assert property (@(posedge clk) disable iff (!rst_n)
        (din_valid && din_ready && ({1'b0, din_channel} < (CHAN_W + 1)'(CHANNELS)))
        |=> !din_ready)
        else $error("input stayed open after an item was accepted");

    a_channel_range: assert property (@(posedge clk) disable iff (!rst_n)
        dout_valid |-> ({1'b0, dout_result_channel} < (CHAN_W + 1)'(CHANNELS)))
        else $error("result for a channel that does not exist");

    a_used_range: assert property (@(posedge clk) disable iff (!rst_n)
        dout_valid |-> ((WINDOW > 31) || ((dout_samples_used != '0)
                        && ({27'd0, dout_samples_used} <= WINDOW))))
        else $error("samples used outside one to the window length");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (dout_valid && !dout_ready) |=> (dout_valid && $stable(dout_result_channel)
                                         && $stable(dout_mean_value)
                                         && $stable(dout_samples_used)))
        else $error("stalled result changed or was dropped");

endmodule

bind multichannel_moving_average mma_checker #(
    .WINDOW   (WINDOW),
    .CHANNELS (CHANNELS)
) u_mma_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .din_valid           (din.valid),
    .din_ready           (din.ready),
    .din_channel         (din.channel),
    .dout_valid          (dout.valid),
    .dout_ready          (dout.ready),
    .dout_result_channel (dout.result_channel),
    .dout_mean_value     (dout.mean_value),
    .dout_samples_used   (dout.samples_used)
);

// ----- bench/moving_average_checker.sv -----
module moving_average_checker #(
    parameter int WINDOW   = 16,
    parameter int CHANNELS = 10
) (
    input  logic                       clk,
    input  logic                       rst_n,
    mma_in_if                          samples,
    mma_out_if                         averages,
    input  logic                       cfg_we,
    input  logic [mma_pkg::MASK_W-1:0] cfg_wdata,
    output int                         error_count,
    output int                         averages_due
);
    timeunit 1ns;
    timeprecision 1ps;
    import mma_pkg::*;

    typedef struct packed {
        logic [CHAN_W-1:0]   channel;
        logic [SAMPLE_W-1:0] mean;
        logic [USED_W-1:0]   used;
    } average_t;

    logic [SAMPLE_W-1:0] ring [CHANNELS][WINDOW];
    int                  ring_pos [CHANNELS];
    int                  held [CHANNELS];
    logic [MASK_W-1:0]   signed_mask;
    average_t            pending_averages [$];

    task report(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        error_count++;
    endtask

    task predict_average(input logic [CHAN_W-1:0] ch, input logic [SAMPLE_W-1:0] raw);
        longint   total;
        int       n;
        bit       as_signed;
        average_t avg;
        as_signed = (ch < MASK_W) && signed_mask[ch];
        ring[ch][ring_pos[ch]] = raw;
        ring_pos[ch] = (ring_pos[ch] + 1) % WINDOW;
        if (held[ch] < WINDOW)
        begin
            held[ch]++;
        end
        n = held[ch];
        total = 0;
        for (int i = 0; i < n; i++)
        begin
            if (as_signed)
            begin
                total += longint'($signed(ring[ch][i]));
            end
            else
            begin
                total += longint'(ring[ch][i]);
            end
        end
        avg.channel = ch;
        avg.mean    = SAMPLE_W'(total / longint'(n));
        avg.used    = USED_W'(n);
        pending_averages.push_back(avg);
    endtask

    task check_average();
        average_t want;
        if (pending_averages.size() == 0)
        begin
            report($sformatf("result with no item pending: channel %0d mean %04h used %0d",
                             averages.result_channel, averages.mean_value,
                             averages.samples_used));
        end
        else
        begin
            want = pending_averages.pop_front();
            if (averages.result_channel !== want.channel)
            begin
                report($sformatf("result_channel expected %0d got %0d",
                                 want.channel, averages.result_channel));
            end
            if (averages.mean_value !== want.mean)
            begin
                report($sformatf("mean_value on channel %0d expected %04h got %04h",
                                 want.channel, want.mean, averages.mean_value));
            end
            if (averages.samples_used !== want.used)
            begin
                report($sformatf("samples_used on channel %0d expected %0d got %0d",
                                 want.channel, want.used, averages.samples_used));
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                ring_pos[c] = 0;
                held[c]     = 0;
            end
            signed_mask = MASK_RESET;
            pending_averages.delete();
            error_count = 0;
            averages_due <= 0;
        end
        else
        begin
            if (averages.valid && averages.ready)
            begin
                check_average();
            end
            if (samples.valid && samples.ready && samples.channel < CHANNELS)
            begin
                predict_average(samples.channel, samples.sample);
            end
            if (cfg_we)
            begin
                signed_mask = cfg_wdata;
            end
            averages_due <= pending_averages.size();
        end
    end

endmodule

// ----- bench/tb_multichannel_moving_average.sv -----
module tb_multichannel_moving_average;
    timeunit 1ns;
    timeprecision 1ps;

    import mma_pkg::*;

    localparam int WINDOW   = 16;
    localparam int CHANNELS = 10;
    localparam int SETTLE   = 60;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_we;
    logic [MASK_W-1:0] cfg_wdata;
    int                error_count;
    int                averages_due;
    int                send_idle;
    int                recv_idle;

    mma_in_if  sample_bus ();
    mma_out_if average_bus ();

    multichannel_moving_average #(
        .WINDOW   (WINDOW),
        .CHANNELS (CHANNELS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .din       (sample_bus),
        .dout      (average_bus),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    moving_average_checker #(
        .WINDOW   (WINDOW),
        .CHANNELS (CHANNELS)
    ) checker_inst (
        .clk          (clk),
        .rst_n        (rst_n),
        .samples      (sample_bus),
        .averages     (average_bus),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .error_count  (error_count),
        .averages_due (averages_due)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        average_bus.ready <= ($urandom_range(99) >= recv_idle);
    end

    initial
    begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    task automatic send_sample(input logic [CHAN_W-1:0] ch, input logic [SAMPLE_W-1:0] s);
        while ($urandom_range(99) < send_idle)
        begin
            sample_bus.valid <= 1'b0;
            @(posedge clk);
        end
        sample_bus.valid   <= 1'b1;
        sample_bus.channel <= ch;
        sample_bus.sample  <= s;
        @(posedge clk);
        while (!sample_bus.ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        sample_bus.valid <= 1'b0;
        @(posedge clk);
        while (averages_due != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_mask(input logic [MASK_W-1:0] value);
        wait_drained();
        repeat (SETTLE) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h8000;
            3: return 16'h7FFF;
            4: return SAMPLE_W'($urandom_range(15));
            5: return 16'hFFFF - SAMPLE_W'($urandom_range(15));
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic run_phase(input int n_items, input int s_idle, input int r_idle,
                             input int pause_at);
        int                sent;
        logic [CHAN_W-1:0] ch;
        send_idle = s_idle;
        recv_idle = r_idle;
        sent = 0;
        while (sent < n_items)
        begin
            if (sent == pause_at)
            begin
                wait_drained();
            end
            if ($urandom_range(99) < 8)
            begin
                ch = CHAN_W'($urandom_range(15, CHANNELS));
            end
            else
            begin
                ch = CHAN_W'($urandom_range(CHANNELS - 1));
                sent++;
            end
            send_sample(ch, pick_sample());
        end
    endtask

    initial
    begin
        rst_n              = 1'b0;
        sample_bus.valid   <= 1'b0;
        sample_bus.channel <= '0;
        sample_bus.sample  <= '0;
        cfg_we             <= 1'b0;
        cfg_wdata          <= '0;
        send_idle          = 0;
        recv_idle          = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_sample(4'd0, 16'h8000);
        send_sample(4'd0, 16'h7FFF);
        send_sample(4'd0, 16'hFFFF);
        send_sample(4'd0, 16'hFFFE);
        send_sample(4'd0, 16'h0001);
        send_sample(4'd1, 16'hFFFF);
        send_sample(4'd1, 16'hFFFF);
        send_sample(4'd1, 16'h0000);
        send_sample(4'd1, 16'h8000);
        send_sample(4'd10, 16'h1234);
        send_sample(4'd15, 16'hFFFF);
        send_sample(4'd9, 16'hFFFF);
        send_sample(4'd9, 16'h8000);
        send_sample(4'd5, 16'h0000);
        send_sample(4'd5, 16'h0003);
        send_sample(4'd7, 16'h7FFF);
        send_sample(4'd7, 16'h7FFF);
        send_sample(4'd7, 16'h0001);
        send_sample(4'd0, 16'hFFFF);
        send_sample(4'd2, 16'h5A5A);

        write_mask(10'h3FF);
        run_phase(170, 14, 70, -1);
        write_mask(10'h000);
        run_phase(170, 70, 14, -1);
        write_mask(MASK_W'($urandom_range(1023)));
        run_phase(170, 0, 0, 85);

        wait_drained();
        repeat (SETTLE) @(posedge clk);
        if (error_count == 0 && averages_due == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
